FILE: rtl/core/text_console_cursor_top_defines.svh
// ----------------------------------------------------------------------------
// Text console cursor: assertion macros
// Shared assertion wrappers; defining ASSERT_OFF leaves them empty.
// ----------------------------------------------------------------------------
`ifndef TEXT_CONSOLE_CURSOR_TOP_DEFINES_SVH
`define TEXT_CONSOLE_CURSOR_TOP_DEFINES_SVH
`ifndef ASSERT_OFF
`define TCC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("text console cursor assertion failed");
`define TCC_ASSERT_NEVER(label, clk, rst, expr) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
      else $error("text console cursor forbidden condition seen");
`else
`define TCC_ASSERT(label, clk, rst, prop)
`define TCC_ASSERT_NEVER(label, clk, rst, expr)
`endif
`endif

FILE: rtl/core/tcc_pkg.sv
// ----------------------------------------------------------------------------
// Text console cursor package
// Payload types, control structs and constants shared by the cursor block.
// ----------------------------------------------------------------------------
package tcc_pkg;

   localparam logic [5:0] MAX_COLUMNS_DEFAULT = 6'd40;
   localparam logic [5:0] MAX_LINES_DEFAULT   = 6'd40;

   localparam logic [7:0] CODE_NEWLINE = 8'd10;
   localparam logic [7:0] CODE_RETURN  = 8'd13;
   localparam logic [7:0] CODE_SPACE   = 8'd32;

   localparam logic [1:0] CSR_COLUMN_COUNT = 2'd0;
   localparam logic [1:0] CSR_LINE_COUNT   = 2'd1;
   localparam logic [1:0] CSR_GLYPH_WIDTH  = 2'd2;
   localparam logic [1:0] CSR_GLYPH_HEIGHT = 2'd3;

   localparam logic [5:0] COLUMN_COUNT_RESET = 6'd40;
   localparam logic [5:0] LINE_COUNT_RESET   = 6'd15;
   localparam logic [5:0] GLYPH_WIDTH_RESET  = 6'd8;
   localparam logic [5:0] GLYPH_HEIGHT_RESET = 6'd16;

   typedef struct packed {
      logic [7:0] char_code;
   } req_payload_type;

   typedef struct packed {
      logic [7:0]  draw_code;
      logic [10:0] pixel_x;
      logic [10:0] pixel_y;
      logic        last;
   } rsp_payload_type;

   typedef struct packed {
      logic capture;
      logic col_zero;
      logic col_inc;
      logic line_adv;
      logic char_emit;
      logic clear_emit;
   } tcc_cmd_type;

   typedef struct packed {
      logic is_newline;
      logic is_return;
      logic col_wrap;
      logic clear_last;
      logic out_free;
   } tcc_status_type;

endpackage

FILE: rtl/core/tcc_stream_if.sv
// ----------------------------------------------------------------------------
// Text console cursor stream interface
// Valid/ready channel carrying one payload item per handshake.
// ----------------------------------------------------------------------------
interface tcc_stream_if #(
   parameter type payload_type = logic
) ();
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

FILE: rtl/core/tcc_datapath.sv
// ----------------------------------------------------------------------------
// Text console cursor datapath
// Configuration registers, cursor, clear counter and the result register.
// ----------------------------------------------------------------------------
`include "text_console_cursor_top_defines.svh"

module tcc_datapath #(
   parameter logic [5:0] MAX_COLUMNS = tcc_pkg::MAX_COLUMNS_DEFAULT,
   parameter logic [5:0] MAX_LINES   = tcc_pkg::MAX_LINES_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  tcc_pkg::tcc_cmd_type     cmd,
   output tcc_pkg::tcc_status_type  status,
   input  logic [7:0]               req_char_code,
   input  logic                     csr_wr_en,
   input  logic [1:0]               csr_index,
   input  logic [5:0]               csr_wdata,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output tcc_pkg::rsp_payload_type rsp_payload
);
   import tcc_pkg::*;

   logic [5:0] col_cnt_ff, col_cnt_in;
   logic [5:0] line_cnt_ff, line_cnt_in;
   logic [5:0] glyph_w_ff, glyph_w_in;
   logic [5:0] glyph_h_ff, glyph_h_in;
   logic [5:0] col_ff, col_in;
   logic [5:0] line_ff, line_in;
   logic [5:0] idx_ff, idx_in;
   logic [7:0] code_ff, code_in;
   logic       rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic [5:0]  cols_eff, lines_eff;
   logic [6:0]  col_next, line_next, idx_next;
   logic [5:0]  line_wrapped;
   logic [5:0]  x_cell;
   logic [11:0] prod_x, prod_y;
   logic        emit;

   // A zero count behaves as one; a count above the build limit is clamped.
   assign cols_eff  = (col_cnt_ff == 6'd0) ? 6'd1 :
                      ((col_cnt_ff > MAX_COLUMNS) ? MAX_COLUMNS : col_cnt_ff);
   assign lines_eff = (line_cnt_ff == 6'd0) ? 6'd1 :
                      ((line_cnt_ff > MAX_LINES) ? MAX_LINES : line_cnt_ff);

   assign col_next  = {1'b0, col_ff} + 7'd1;
   assign line_next = {1'b0, line_ff} + 7'd1;
   assign idx_next  = {1'b0, idx_ff} + 7'd1;
   assign line_wrapped = (line_next >= {1'b0, lines_eff}) ? 6'd0 : line_next[5:0];

   assign status.is_newline = (req_char_code == CODE_NEWLINE);
   assign status.is_return  = (req_char_code == CODE_RETURN);
   assign status.col_wrap   = (col_next >= {1'b0, cols_eff});
   assign status.clear_last = (idx_next >= {1'b0, cols_eff});
   assign status.out_free   = !rsp_valid_ff || rsp_ready;

   assign emit   = cmd.char_emit || cmd.clear_emit;
   assign x_cell = cmd.char_emit ? col_ff : idx_ff;
   assign prod_x = x_cell * glyph_w_ff;
   assign prod_y = line_ff * glyph_h_ff;

   always_comb begin
      col_cnt_in  = col_cnt_ff;
      line_cnt_in = line_cnt_ff;
      glyph_w_in  = glyph_w_ff;
      glyph_h_in  = glyph_h_ff;
      if (csr_wr_en) begin
         case (csr_index)
            CSR_COLUMN_COUNT: col_cnt_in  = csr_wdata;
            CSR_LINE_COUNT:   line_cnt_in = csr_wdata;
            CSR_GLYPH_WIDTH:  glyph_w_in  = csr_wdata;
            CSR_GLYPH_HEIGHT: glyph_h_in  = csr_wdata;
            default: begin
            end
         endcase
      end

      col_in = col_ff;
      if (cmd.col_zero) begin
         col_in = 6'd0;
      end else if (cmd.col_inc) begin
         col_in = col_next[5:0];
      end

      line_in = cmd.line_adv ? line_wrapped : line_ff;

      idx_in = idx_ff;
      if (cmd.line_adv) begin
         idx_in = 6'd0;
      end else if (cmd.clear_emit) begin
         idx_in = idx_next[5:0];
      end

      code_in = cmd.capture ? req_char_code : code_ff;

      rsp_valid_in = rsp_valid_ff;
      if (emit) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      rsp_data_in = rsp_data_ff;
      if (emit) begin
         rsp_data_in.draw_code = cmd.char_emit ? code_ff : CODE_SPACE;
         rsp_data_in.pixel_x   = prod_x[10:0];
         rsp_data_in.pixel_y   = prod_y[10:0];
         rsp_data_in.last      = cmd.char_emit ? !status.col_wrap : status.clear_last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff   <= COLUMN_COUNT_RESET;
         line_cnt_ff  <= LINE_COUNT_RESET;
         glyph_w_ff   <= GLYPH_WIDTH_RESET;
         glyph_h_ff   <= GLYPH_HEIGHT_RESET;
         col_ff       <= 6'd0;
         line_ff      <= 6'd0;
         idx_ff       <= 6'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         col_cnt_ff   <= col_cnt_in;
         line_cnt_ff  <= line_cnt_in;
         glyph_w_ff   <= glyph_w_in;
         glyph_h_ff   <= glyph_h_in;
         col_ff       <= col_in;
         line_ff      <= line_in;
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      code_ff     <= code_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

   `TCC_ASSERT(a_clear_cell_in_line, clock, reset, cmd.clear_emit |-> (idx_ff < cols_eff))
   `TCC_ASSERT(a_line_advance_wraps, clock, reset, cmd.line_adv |=> (line_ff < $past(lines_eff)))

endmodule

FILE: rtl/core/tcc_controller.sv
// ----------------------------------------------------------------------------
// Text console cursor controller
// Sequences the capture, character draw and line clear of each item.
// ----------------------------------------------------------------------------
`include "text_console_cursor_top_defines.svh"

module tcc_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  tcc_pkg::tcc_status_type status,
   output tcc_pkg::tcc_cmd_type    cmd
);
   import tcc_pkg::*;

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_CHAR  = 2'd1;
   localparam logic [1:0] ST_CLEAR = 2'd2;

   logic [1:0] state_ff, state_in;
   logic       emit_any;
   logic       clear_done;

   assign req_ready  = (state_ff == ST_IDLE);
   assign emit_any   = cmd.char_emit || cmd.clear_emit;
   assign clear_done = (state_ff == ST_CLEAR) && status.out_free && status.clear_last;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (status.is_newline) begin
                  cmd.col_zero = 1'b1;
               end else if (status.is_return) begin
                  cmd.line_adv = 1'b1;
                  state_in     = ST_CLEAR;
               end else begin
                  state_in = ST_CHAR;
               end
            end
         end
         ST_CHAR: begin
            if (status.out_free) begin
               cmd.char_emit = 1'b1;
               // Reaching the end of the line wraps the cursor and clears the new line.
               if (status.col_wrap) begin
                  cmd.col_zero = 1'b1;
                  cmd.line_adv = 1'b1;
                  state_in     = ST_CLEAR;
               end else begin
                  cmd.col_inc = 1'b1;
                  state_in    = ST_IDLE;
               end
            end
         end
         ST_CLEAR: begin
            if (status.out_free) begin
               cmd.clear_emit = 1'b1;
               if (status.clear_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   `TCC_ASSERT_NEVER(a_emit_into_full, clock, reset, emit_any && !status.out_free)
   `TCC_ASSERT(a_clear_ends_idle, clock, reset, clear_done |=> (state_ff == ST_IDLE))

endmodule

FILE: rtl/core/text_console_cursor_top.sv
// ----------------------------------------------------------------------------
// Text console cursor
// Turns character codes into character-cell draw commands.
// ----------------------------------------------------------------------------
// Usage:
// req_ch carries one character code per item; rsp_ch carries draw commands
// (code, pixel x/y, last). The csr_ port writes column count, line count,
// glyph width and glyph height; write it only while the block is idle.
// A newline code gives no draw. An ordinary code is captured, then its draw
// is loaded into the result register once that register is free. A carriage
// return, or a character that fills the line, is followed by one space draw
// per column, issued one per cycle while the receiver keeps up. The controller
// handles one item at a time; the single result register sets the pace of one
// draw per cycle while the receiver takes each draw.
// A stalled receiver holds the result register and the sequencer waits;
// nothing is dropped. A new item can be taken while the final draw of the
// previous one still waits in the result register.
// Reset clears the cursor to column 0, line 0 and loads the register
// defaults: 40 columns, 15 lines, 8 by 16 pixel glyphs.
// ----------------------------------------------------------------------------
module text_console_cursor_top #(
   parameter logic [5:0] MAX_COLUMNS = tcc_pkg::MAX_COLUMNS_DEFAULT,
   parameter logic [5:0] MAX_LINES   = tcc_pkg::MAX_LINES_DEFAULT
) (
   input  logic       clock,
   input  logic       reset,
   tcc_stream_if.sink   req_ch,
   tcc_stream_if.source rsp_ch,
   input  logic       csr_wr_en,
   input  logic [1:0] csr_index,
   input  logic [5:0] csr_wdata
);
   import tcc_pkg::*;

   tcc_cmd_type     cmd;
   tcc_status_type  status;
   rsp_payload_type rsp_payload;
   logic            rsp_valid;
   logic            req_ready;

   tcc_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   tcc_datapath #(
      .MAX_COLUMNS (MAX_COLUMNS),
      .MAX_LINES   (MAX_LINES)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_char_code (req_ch.payload.char_code),
      .csr_wr_en     (csr_wr_en),
      .csr_index     (csr_index),
      .csr_wdata     (csr_wdata),
      .rsp_valid     (rsp_valid),
      .rsp_ready     (rsp_ch.ready),
      .rsp_payload   (rsp_payload)
   );

   assign req_ch.ready   = req_ready;
   assign rsp_ch.valid   = rsp_valid;
   assign rsp_ch.payload = rsp_payload;

endmodule

FILE: dv/tb_text_console_cursor_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console cursor testbench
// Feeds character codes through the request channel and checks every draw
// command against a cursor model kept in the bench. A short scripted part
// covers field extremes, newline, carriage return, column and line wrap,
// out-of-range counts and a stale cursor. Sweeps that drive coordinate
// overflow and random text lines under random register settings follow.
// Both sides of the stream idle at random.
// ----------------------------------------------------------------------------
module tb_text_console_cursor_top;
   import tcc_pkg::*;

   localparam int CLOCK_PERIOD  = 10;
   localparam int RESET_CYCLES  = 7;
   localparam int SETTLE_CYCLES = 4;
   localparam int TAIL_CYCLES   = 50;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int RANDOM_CODES  = 150;

   typedef enum logic [1:0] {
      STEP_CODE,
      STEP_SETTING
   } step_kind_type;

   typedef struct packed {
      step_kind_type   kind;
      logic [1:0]      csr_index;      // only used by setting steps
      logic [7:0]      value;
      logic            fixed_result;   // draw typed in below replaces the prediction
      logic            fixed_has_draw;
      rsp_payload_type draw;
   } script_step_type;

   localparam rsp_payload_type NO_DRAW = '0;

   // Register defaults after reset: 40 columns, 15 lines, 8 by 16 glyphs.
   localparam script_step_type SCRIPT [27] = '{
      '{STEP_CODE, CSR_COLUMN_COUNT, 8'd65, 1'b1, 1'b1, '{8'd65, 11'd0, 11'd0, 1'b1}},
      '{STEP_CODE, CSR_COLUMN_COUNT, 8'd0, 1'b1, 1'b1, '{8'd0, 11'd8, 11'd0, 1'b1}},
      '{STEP_CODE, CSR_COLUMN_COUNT, 8'd255, 1'b1, 1'b1, '{8'd255, 11'd16, 11'd0, 1'b1}},
      '{STEP_CODE, CSR_COLUMN_COUNT, CODE_NEWLINE, 1'b1, 1'b0, NO_DRAW},
      '{STEP_CODE, CSR_COLUMN_COUNT, 8'd85, 1'b1, 1'b1, '{8'd85, 11'd0, 11'd0, 1'b1}},
      '{STEP_CODE, CSR_COLUMN_COUNT, CODE_RETURN, 1'b0, 1'b0, NO_DRAW},
      '{STEP_CODE, CSR_COLUMN_COUNT, 8'd170, 1'b1, 1'b1, '{8'd170, 11'd8, 11'd16, 1'b1}},
      // Shrinking the line leaves the cursor beyond the column count.
      '{STEP_SETTING, CSR_COLUMN_COUNT, 8'd2, 1'b0, 1'b0, NO_DRAW},
      '{STEP_SETTING, CSR_GLYPH_WIDTH, 8'd63, 1'b0, 1'b0, NO_DRAW},
      '{STEP_SETTING, CSR_GLYPH_HEIGHT, 8'd63, 1'b0, 1'b0, NO_DRAW},
      '{STEP_CODE, CSR_COLUMN_COUNT, 8'd33, 1'b0, 1'b0, NO_DRAW},
      '{STEP_CODE, CSR_COLUMN_COUNT, 8'd90, 1'b0, 1'b0, NO_DRAW},
      '{STEP_CODE, CSR_COLUMN_COUNT, 8'd91, 1'b0, 1'b0, NO_DRAW},
      // Zero counts behave as one.
      '{STEP_SETTING, CSR_LINE_COUNT, 8'd0, 1'b0, 1'b0, NO_DRAW},
      '{STEP_SETTING, CSR_COLUMN_COUNT, 8'd0, 1'b0, 1'b0, NO_DRAW},
      '{STEP_CODE, CSR_COLUMN_COUNT, CODE_RETURN, 1'b1, 1'b1, '{CODE_SPACE, 11'd0, 11'd0, 1'b1}},
      '{STEP_CODE, CSR_COLUMN_COUNT, 8'd200, 1'b0, 1'b0, NO_DRAW},
      // Counts above the maximum are clamped.
      '{STEP_SETTING, CSR_COLUMN_COUNT, 8'd63, 1'b0, 1'b0, NO_DRAW},
      '{STEP_SETTING, CSR_LINE_COUNT, 8'd63, 1'b0, 1'b0, NO_DRAW},
      '{STEP_SETTING, CSR_GLYPH_WIDTH, 8'd32, 1'b0, 1'b0, NO_DRAW},
      '{STEP_SETTING, CSR_GLYPH_HEIGHT, 8'd1, 1'b0, 1'b0, NO_DRAW},
      '{STEP_CODE, CSR_COLUMN_COUNT, CODE_RETURN, 1'b0, 1'b0, NO_DRAW},
      '{STEP_CODE, CSR_COLUMN_COUNT, CODE_RETURN, 1'b0, 1'b0, NO_DRAW},
      '{STEP_CODE, CSR_COLUMN_COUNT, CODE_RETURN, 1'b0, 1'b0, NO_DRAW},
      // The line now sits beyond the new count and wraps on its next advance.
      '{STEP_SETTING, CSR_LINE_COUNT, 8'd2, 1'b0, 1'b0, NO_DRAW},
      '{STEP_CODE, CSR_COLUMN_COUNT, CODE_RETURN, 1'b0, 1'b0, NO_DRAW},
      '{STEP_CODE, CSR_COLUMN_COUNT, 8'd97, 1'b1, 1'b1, '{8'd97, 11'd0, 11'd0, 1'b1}}
   };

   logic       clock = 1'b0;
   logic       reset;
   logic       csr_wr_en;
   logic [1:0] csr_index;
   logic [5:0] csr_wdata;

   tcc_stream_if #(.payload_type(req_payload_type)) req_ch ();
   tcc_stream_if #(.payload_type(rsp_payload_type)) rsp_ch ();

   text_console_cursor_top i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Cursor model state and its copy of the registers.
   logic [5:0] column_count_reg;
   logic [5:0] line_count_reg;
   logic [5:0] glyph_width_reg;
   logic [5:0] glyph_height_reg;
   logic [5:0] cursor_col;
   logic [5:0] cursor_line;

   rsp_payload_type pending_draws [$];

   int unsigned mismatch_count = 0;
   int unsigned cycle_count    = 0;
   int unsigned codes_sent     = 0;
   int          req_gap        = 1;
   int          rsp_stall      = 0;
   bit          idle_off       = 1'b0;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   function automatic int pick_gap();
      return idle_off ? 0 : int'($urandom_range(0, 15));
   endfunction

   function automatic logic [7:0] pick_glyph_code();
      logic [7:0] code;
      do code = 8'($urandom_range(0, 255));
      while (code == CODE_NEWLINE || code == CODE_RETURN);
      return code;
   endfunction

   // Mostly the legal range and its ends, now and then any 6-bit value.
   function automatic logic [5:0] pick_setting(input int lo, input int hi);
      case ($urandom_range(0, 3))
         0: return 6'($urandom_range(0, 63));
         1: return 6'(lo);
         2: return 6'(hi);
         default: return 6'($urandom_range(lo, hi));
      endcase
   endfunction

   function automatic logic [5:0] effective_count(input logic [5:0] count,
                                                  input logic [5:0] cap);
      if (count == 6'd0) return 6'd1;
      if (count > cap) return cap;
      return count;
   endfunction

   function automatic rsp_payload_type cell_draw(input logic [7:0] code,
                                                 input logic [5:0] col,
                                                 input logic [5:0] line);
      rsp_payload_type d;
      logic [11:0] x_full;
      logic [11:0] y_full;
      x_full = col * glyph_width_reg;
      y_full = line * glyph_height_reg;
      d.draw_code = code;
      d.pixel_x   = x_full[10:0];
      d.pixel_y   = y_full[10:0];
      d.last      = 1'b0;
      return d;
   endfunction

   // Moves to the next line and blanks every cell of it.
   function automatic void advance_line(input logic [5:0] cols, input logic [5:0] lines,
                                        inout rsp_payload_type draws [$]);
      logic [6:0] next_line;
      next_line   = cursor_line + 7'd1;
      cursor_line = (next_line >= lines) ? 6'd0 : next_line[5:0];
      for (int i = 0; i < cols; i++)
         draws.push_back(cell_draw(CODE_SPACE, 6'(i), cursor_line));
   endfunction

   function automatic void predict_draws(input logic [7:0] code,
                                         output rsp_payload_type draws [$]);
      logic [5:0] cols;
      logic [5:0] lines;
      logic [6:0] next_col;
      draws = {};
      cols  = effective_count(column_count_reg, MAX_COLUMNS_DEFAULT);
      lines = effective_count(line_count_reg, MAX_LINES_DEFAULT);
      if (code == CODE_NEWLINE) begin
         cursor_col = 6'd0;
      end else if (code == CODE_RETURN) begin
         advance_line(cols, lines, draws);
      end else begin
         // A stale column is drawn first and only then wrapped.
         draws.push_back(cell_draw(code, cursor_col, cursor_line));
         next_col = cursor_col + 7'd1;
         if (next_col >= cols) begin
            cursor_col = 6'd0;
            advance_line(cols, lines, draws);
         end else begin
            cursor_col = next_col[5:0];
         end
      end
      if (draws.size() != 0) draws[draws.size() - 1].last = 1'b1;
   endfunction

   task automatic report_mismatch(input string what);
      mismatch_count++;
      $display("[%0t] MISMATCH: %s", $time, what);
   endtask

   task automatic check_draw(input rsp_payload_type got);
      rsp_payload_type want;
      if (pending_draws.size() == 0) begin
         report_mismatch($sformatf("unexpected draw code %0d x %0d y %0d last %0d",
                                   got.draw_code, got.pixel_x, got.pixel_y, got.last));
      end else begin
         want = pending_draws.pop_front();
         if (got.draw_code !== want.draw_code)
            report_mismatch($sformatf("draw_code %0d, expected %0d",
                                      got.draw_code, want.draw_code));
         if (got.pixel_x !== want.pixel_x)
            report_mismatch($sformatf("pixel_x %0d, expected %0d", got.pixel_x, want.pixel_x));
         if (got.pixel_y !== want.pixel_y)
            report_mismatch($sformatf("pixel_y %0d, expected %0d", got.pixel_y, want.pixel_y));
         if (got.last !== want.last)
            report_mismatch($sformatf("last %0d, expected %0d", got.last, want.last));
      end
   endtask

   // Presents one code and waits for it to be taken. Valid stays high only
   // when the next item follows without a gap.
   task automatic send_code(input logic [7:0] code,
                            input logic fixed_result = 1'b0,
                            input logic fixed_has_draw = 1'b0,
                            input rsp_payload_type fixed_draw = '0);
      rsp_payload_type predicted [$];
      repeat (req_gap) @(posedge clock);
      req_ch.payload <= req_payload_type'(code);
      req_ch.valid   <= 1'b1;
      do @(posedge clock);
      while (req_ch.ready !== 1'b1);
      predict_draws(code, predicted);
      if (fixed_result) begin
         if (fixed_has_draw) pending_draws.push_back(fixed_draw);
      end else begin
         foreach (predicted[j]) pending_draws.push_back(predicted[j]);
      end
      codes_sent++;
      req_gap = pick_gap();
      if (req_gap != 0) req_ch.valid <= 1'b0;
   endtask

   task automatic drain_draws();
      if (req_gap == 0) begin
         req_ch.valid <= 1'b0;
         req_gap = 1;
      end
      while (pending_draws.size() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [1:0] index, input logic [5:0] value);
      drain_draws();
      // A newline item gives no draw, so wait for the block to settle before writing.
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (index)
         CSR_COLUMN_COUNT: column_count_reg = value;
         CSR_LINE_COUNT:   line_count_reg   = value;
         CSR_GLYPH_WIDTH:  glyph_width_reg  = value;
         CSR_GLYPH_HEIGHT: glyph_height_reg = value;
         default: ;
      endcase
   endtask

   always @(posedge clock) begin : draw_sink
      int n;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         rsp_stall    <= 0;
      end else if (rsp_ch.ready === 1'b1) begin
         if (rsp_ch.valid === 1'b1) begin
            check_draw(rsp_ch.payload);
            n = pick_gap();
            if (n != 0) begin
               rsp_ch.ready <= 1'b0;
               rsp_stall    <= n;
            end
         end
      end else if (rsp_stall <= 1) begin
         rsp_ch.ready <= 1'b1;
      end else begin
         rsp_stall <= rsp_stall - 1;
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   initial begin : stimulus
      int line_len;
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.payload = '0;
      csr_wr_en      = 1'b0;
      csr_index      = CSR_COLUMN_COUNT;
      csr_wdata      = '0;

      column_count_reg = COLUMN_COUNT_RESET;
      line_count_reg   = LINE_COUNT_RESET;
      glyph_width_reg  = GLYPH_WIDTH_RESET;
      glyph_height_reg = GLYPH_HEIGHT_RESET;
      cursor_col       = 6'd0;
      cursor_line      = 6'd0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      foreach (SCRIPT[i]) begin
         if (SCRIPT[i].kind == STEP_SETTING)
            write_register(SCRIPT[i].csr_index, SCRIPT[i].value[5:0]);
         else
            send_code(SCRIPT[i].value, SCRIPT[i].fixed_result, SCRIPT[i].fixed_has_draw,
                      SCRIPT[i].draw);
      end

      // Sweep the column across a full line with the widest glyphs, so that
      // the x coordinate overflows and the line wraps.
      write_register(CSR_COLUMN_COUNT, 6'd63);
      write_register(CSR_LINE_COUNT, 6'd40);
      write_register(CSR_GLYPH_WIDTH, 6'd63);
      write_register(CSR_GLYPH_HEIGHT, 6'd63);
      repeat (45) send_code(pick_glyph_code());

      // One column per line: every item advances the line, sweeping y through
      // overflow and the line wrap. No idling on either side here.
      write_register(CSR_COLUMN_COUNT, 6'd1);
      write_register(CSR_LINE_COUNT, 6'd63);
      write_register(CSR_GLYPH_WIDTH, pick_setting(8, 32));
      idle_off = 1'b1;
      repeat (42) send_code(pick_glyph_code());
      idle_off = 1'b0;

      // Random lines of text under random settings.
      while (codes_sent < RANDOM_CODES) begin
         write_register(CSR_COLUMN_COUNT, pick_setting(1, 40));
         write_register(CSR_LINE_COUNT, pick_setting(1, 40));
         write_register(CSR_GLYPH_WIDTH, pick_setting(8, 32));
         write_register(CSR_GLYPH_HEIGHT, pick_setting(1, 32));
         idle_off = ($urandom_range(0, 3) == 0);
         repeat ($urandom_range(2, 5)) begin
            line_len = ($urandom_range(0, 4) == 0) ? $urandom_range(21, 44)
                                                   : $urandom_range(0, 20);
            repeat (line_len) begin
               if ($urandom_range(0, 9) == 0) send_code(8'($urandom_range(0, 255)));
               else send_code(pick_glyph_code());
            end
            case ($urandom_range(0, 3))
               0: begin
                  send_code(CODE_RETURN);
                  send_code(CODE_NEWLINE);
               end
               1: begin
                  send_code(CODE_NEWLINE);
                  send_code(CODE_RETURN);
               end
               2: send_code(CODE_RETURN);
               default: send_code(CODE_NEWLINE);
            endcase
            // Now and then let every outstanding draw come back first.
            if ($urandom_range(0, 4) == 0) drain_draws();
         end
      end

      drain_draws();
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
